// ===== rtl/cspm_pkg.sv =====
package cspm_pkg;

    typedef enum logic [1:0] {
        ACT_TICK  = 2'd0,
        ACT_MOVE  = 2'd1,
        ACT_PLACE = 2'd2,
        ACT_NONE  = 2'd3
    } action_t;

    // datapath operations issued by the controller
    typedef enum logic [3:0] {
        OP_IDLE,
        OP_LOAD,
        OP_SQ,
        OP_SQRT,
        OP_STEP,
        OP_DIVLD,
        OP_DIV,
        OP_AXIS,
        OP_APPLY,
        OP_FINISH
    } op_t;

    typedef struct packed {
        op_t        op;
        logic [1:0] axis;
    } cspm_cmd_t;

    typedef struct packed {
        logic done;
        logic step_ge;
    } cspm_sts_t;

endpackage

// ===== rtl/cspm_datapath.sv =====
module cspm_datapath
    import cspm_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  cspm_cmd_t         cmd,
    output cspm_sts_t         sts,
    input  logic [1:0]        in_action,
    input  logic signed [31:0] in_x,
    input  logic signed [31:0] in_y,
    input  logic signed [31:0] in_z,
    input  logic [31:0]       in_speed,
    input  logic [31:0]       in_elapsed,
    output logic [31:0]       out_x,
    output logic [31:0]       out_y,
    output logic [31:0]       out_z,
    output logic              out_arrived,
    output logic              out_moving,
    output logic [31:0]       out_travel
);

    logic signed [31:0] pos_reg [3];
    logic signed [31:0] goal_reg [3];
    logic [31:0] speed_reg;
    logic        moving_reg;
    logic [1:0]  act_reg;
    logic [31:0] elapsed_reg;
    logic [32:0] mag_reg [3];
    logic [67:0] norm_reg;      // sum of squares, up to 3 * 2^64, top pair zero
    logic [35:0] root_reg;
    logic [69:0] rem_reg;       // running remainder of sqrt
    logic [6:0]  cnt_reg;
    logic [47:0] step_reg;
    // divider: num shifted in bit by bit
    logic [63:0] quo_reg;
    logic [64:0] drem_reg;
    logic [63:0] num_reg;
    logic [35:0] den_reg;
    logic        arrived_reg;
    logic [31:0] travel_reg;
    logic [65:0] prod_reg;

    logic [65:0] sq;
    logic [69:0] trial, rsh;
    logic [64:0] dsh;
    logic [63:0] numer;
    logic [32:0] dmag;
    logic [63:0] delta;
    logic signed [33:0] npos;

    function automatic logic [32:0] absdiff(logic signed [31:0] a, logic signed [31:0] b);
        logic signed [32:0] d;
        d = 33'(a) - 33'(b);
        return d[32] ? 33'(-d) : 33'(d);
    endfunction

    always_comb begin
        sq  = {33'd0, mag_reg[cmd.axis]} * {33'd0, mag_reg[cmd.axis]};
        // restoring sqrt, 2 bits of radicand per step
        rsh   = {rem_reg[67:0], norm_reg[67:66]};
        trial = {32'd0, root_reg, 2'b01};
        dsh   = {drem_reg[63:0], num_reg[63]};
        numer = 64'd0;
        dmag  = 33'd0;
        npos  = 34'sd0;
        if (act_reg == ACT_MOVE) numer = {12'd0, root_reg, 16'd0};
        else                     numer = {step_reg[35:0], 28'd0};
        dmag  = absdiff(goal_reg[cmd.axis], pos_reg[cmd.axis]);
        delta = {30'd0, prod_reg[61:28]};
        if (goal_reg[cmd.axis] >= pos_reg[cmd.axis])
            npos = 34'(pos_reg[cmd.axis]) + 34'(delta[32:0]);
        else
            npos = 34'(pos_reg[cmd.axis]) - 34'(delta[32:0]);
    end

    assign sts.done    = (cnt_reg == 7'd0);
    assign sts.step_ge = ({12'd0, step_reg} >= {24'd0, root_reg});

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < 3; i++) begin
                pos_reg[i]  <= '0;
                goal_reg[i] <= '0;
            end
            speed_reg   <= '0;
            moving_reg  <= 1'b0;
            cnt_reg     <= '0;
            arrived_reg <= 1'b0;
            travel_reg  <= '0;
        end else begin
            unique case (cmd.op)
                OP_IDLE: ;
                OP_LOAD: begin
                    act_reg     <= in_action;
                    elapsed_reg <= in_elapsed;
                    arrived_reg <= 1'b0;
                    travel_reg  <= '0;
                    norm_reg    <= '0;
                    unique case (action_t'(in_action))
                        ACT_PLACE: begin
                            pos_reg[0] <= in_x;
                            pos_reg[1] <= in_y;
                            pos_reg[2] <= in_z;
                            moving_reg <= 1'b0;
                        end
                        ACT_MOVE: begin
                            goal_reg[0] <= in_x;
                            goal_reg[1] <= in_y;
                            goal_reg[2] <= in_z;
                            speed_reg   <= in_speed;
                            moving_reg  <= 1'b1;
                        end
                        default: ;
                    endcase
                    // magnitudes against current position vs incoming or goal
                    mag_reg[0] <= absdiff((in_action == ACT_MOVE) ? in_x : goal_reg[0],
                                          pos_reg[0]);
                    mag_reg[1] <= absdiff((in_action == ACT_MOVE) ? in_y : goal_reg[1],
                                          pos_reg[1]);
                    mag_reg[2] <= absdiff((in_action == ACT_MOVE) ? in_z : goal_reg[2],
                                          pos_reg[2]);
                    root_reg <= '0;
                    rem_reg  <= '0;
                    cnt_reg  <= 7'd34;
                end
                OP_SQ: begin
                    norm_reg <= norm_reg + {2'b0, sq};
                end
                OP_SQRT: begin
                    // 34 steps cover the radicand as 68 bits
                    if (rsh >= trial) begin
                        rem_reg  <= rsh - trial;
                        root_reg <= {root_reg[34:0], 1'b1};
                    end else begin
                        rem_reg  <= rsh;
                        root_reg <= {root_reg[34:0], 1'b0};
                    end
                    norm_reg <= {norm_reg[65:0], 2'b00};
                    cnt_reg  <= cnt_reg - 7'd1;
                end
                OP_STEP: begin
                    step_reg <= 48'(({32'd0, elapsed_reg} * {32'd0, speed_reg}) >> 16);
                end
                OP_DIVLD: begin
                    num_reg  <= numer;
                    den_reg  <= (act_reg == ACT_MOVE) ? {4'd0, speed_reg} : root_reg;
                    drem_reg <= '0;
                    quo_reg  <= '0;
                    cnt_reg  <= 7'd64;
                end
                OP_DIV: begin
                    if (dsh >= {29'd0, den_reg}) begin
                        drem_reg <= dsh - {29'd0, den_reg};
                        quo_reg  <= {quo_reg[62:0], 1'b1};
                    end else begin
                        drem_reg <= dsh;
                        quo_reg  <= {quo_reg[62:0], 1'b0};
                    end
                    num_reg <= {num_reg[62:0], 1'b0};
                    cnt_reg <= cnt_reg - 7'd1;
                end
                OP_AXIS: begin
                    // quotient is ratio (< 2^28) here
                    prod_reg <= 66'({33'd0, dmag} * {36'd0, quo_reg[29:0]});
                end
                OP_APPLY: begin
                    pos_reg[cmd.axis] <= npos[31:0];
                end
                OP_FINISH: begin
                    cnt_reg <= '0;
                    if (act_reg == ACT_MOVE) begin
                        if (speed_reg == 32'd0 || quo_reg[63:32] != 32'd0)
                            travel_reg <= 32'hFFFF_FFFF;
                        else
                            travel_reg <= quo_reg[31:0];
                    end else if (act_reg == ACT_TICK && moving_reg && sts.step_ge) begin
                        arrived_reg <= 1'b1;
                        moving_reg  <= 1'b0;
                        pos_reg[0]  <= goal_reg[0];
                        pos_reg[1]  <= goal_reg[1];
                        pos_reg[2]  <= goal_reg[2];
                    end
                end
                default: ;
            endcase
        end
    end

    assign out_x       = pos_reg[0];
    assign out_y       = pos_reg[1];
    assign out_z       = pos_reg[2];
    assign out_arrived = arrived_reg;
    assign out_moving  = moving_reg;
    assign out_travel  = travel_reg;

endmodule

// ===== rtl/cspm_ctrl.sv =====
module cspm_ctrl
    import cspm_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [1:0] in_action,
    input  logic       moving,
    output logic       out_valid,
    input  logic       out_ready,
    output cspm_cmd_t  cmd,
    input  cspm_sts_t  sts
);

    typedef enum logic [3:0] {
        S_IDLE, S_SQ, S_SQRT, S_STEP, S_CHECK, S_DIVLD, S_DIV,
        S_AXPROD, S_AXAPPLY, S_FIN, S_OUT
    } state_t;

    state_t     state_reg;
    logic [1:0] axis_reg;
    logic       move_reg;
    logic       valid_reg;

    assign in_ready  = (state_reg == S_IDLE) && !valid_reg;
    assign out_valid = valid_reg;

    always_comb begin
        cmd.axis = axis_reg;
        unique case (state_reg)
            S_IDLE:    cmd.op = (in_valid && in_ready) ? OP_LOAD : OP_IDLE;
            S_SQ:      cmd.op = OP_SQ;
            S_SQRT:    cmd.op = sts.done ? OP_IDLE : OP_SQRT;
            S_STEP:    cmd.op = OP_STEP;
            S_CHECK:   cmd.op = OP_IDLE;
            S_DIVLD:   cmd.op = OP_DIVLD;
            S_DIV:     cmd.op = sts.done ? OP_IDLE : OP_DIV;
            S_AXPROD:  cmd.op = OP_AXIS;
            S_AXAPPLY: cmd.op = OP_APPLY;
            S_FIN:     cmd.op = OP_FINISH;
            S_OUT:     cmd.op = OP_IDLE;
            default:   cmd.op = OP_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            axis_reg  <= '0;
            move_reg  <= 1'b0;
            valid_reg <= 1'b0;
        end else begin
            if (valid_reg && out_ready) valid_reg <= 1'b0;
            unique case (state_reg)
                S_IDLE: if (in_valid && in_ready) begin
                    axis_reg <= '0;
                    move_reg <= (in_action == ACT_MOVE);
                    if (in_action == ACT_MOVE || (in_action == ACT_TICK && moving))
                        state_reg <= S_SQ;
                    else
                        state_reg <= S_FIN;
                end
                S_SQ: begin
                    if (axis_reg == 2'd2) begin
                        axis_reg  <= '0;
                        state_reg <= S_SQRT;
                    end else axis_reg <= axis_reg + 2'd1;
                end
                S_SQRT: if (sts.done)
                    state_reg <= move_reg ? S_DIVLD : S_STEP;
                S_STEP:  state_reg <= S_CHECK;
                S_CHECK: state_reg <= sts.step_ge ? S_FIN : S_DIVLD;
                S_DIVLD: state_reg <= S_DIV;
                // count reaches zero after the last quotient bit
                S_DIV: if (sts.done)
                    state_reg <= move_reg ? S_FIN : S_AXPROD;
                S_AXPROD:  state_reg <= S_AXAPPLY;
                S_AXAPPLY: begin
                    if (axis_reg == 2'd2) state_reg <= S_FIN;
                    else begin
                        axis_reg  <= axis_reg + 2'd1;
                        state_reg <= S_AXPROD;
                    end
                end
                S_FIN: begin
                    valid_reg <= 1'b1;
                    state_reg <= S_OUT;
                end
                S_OUT: if (!valid_reg || out_ready) state_reg <= S_IDLE;
                default: state_reg <= S_IDLE;
            endcase
        end
    end

endmodule

// ===== rtl/constant_speed_point_move_top.sv =====
// Point mover: one result per input transfer. Place and idle ticks go
// straight to finish; a move runs squares, square root and divider; a tick
// that arrives runs squares, square root and step check; a moving tick
// short of the goal adds the divide and three axis multiply/apply steps.
// The shared radix-2 divider sets the rate; a stalled receiver adds its wait.
// tdata fields pack from bit 0: s: coord_x, coord_y, coord_z, move_speed,
// elapsed; m: pos_x, pos_y, pos_z, travel_time. tuser: action / arrived,is_moving.
module constant_speed_point_move_top
    import cspm_pkg::*;
(
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [159:0] s_tdata,  // coord_x, coord_y, coord_z, move_speed, elapsed
    input  logic [1:0]   s_tuser,  // action
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [127:0] m_tdata,  // pos_x, pos_y, pos_z, travel_time
    output logic [1:0]   m_tuser   // arrived, is_moving
);

    cspm_cmd_t cmd;
    cspm_sts_t sts;
    logic [31:0] px, py, pz, tt;
    logic arr, mov;

    cspm_ctrl u_ctrl (
        .aclk, .aresetn,
        .in_valid(s_tvalid), .in_ready(s_tready), .in_action(s_tuser),
        .moving(mov), .out_valid(m_tvalid), .out_ready(m_tready),
        .cmd, .sts
    );

    cspm_datapath u_dp (
        .aclk, .aresetn, .cmd, .sts,
        .in_action(s_tuser),
        .in_x(s_tdata[31:0]), .in_y(s_tdata[63:32]), .in_z(s_tdata[95:64]),
        .in_speed(s_tdata[127:96]), .in_elapsed(s_tdata[159:128]),
        .out_x(px), .out_y(py), .out_z(pz),
        .out_arrived(arr), .out_moving(mov), .out_travel(tt)
    );

    assign m_tdata = {tt, pz, py, px};
    assign m_tuser = {mov, arr};

endmodule
